@@ rtl/emb_pkg.sv @@
// Shared types, register codes and the per-channel emboss arithmetic.
package emb_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int BIAS_W       = 8;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BIAS_OFFSET  = 2'd2;

    localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 13'd480;
    localparam logic [BIAS_W-1:0]       RESET_BIAS   = 8'd128;

    typedef struct packed {
        logic       action;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       frame_end;
    } result_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // One window column: up is two rows back, low is the current row.
    typedef struct packed {
        rgb_t up;
        rgb_t mid;
        rgb_t low;
    } column_t;

    typedef struct packed {
        rgb_t upper;
        rgb_t lower;
    } line_entry_t;

    typedef struct packed {
        logic emit;
        logic frame_end;
        logic top;
        logic bot;
        logic left;
        logic right;
    } tap_ctrl_t;

    // -2*tl - tc - ml + mc + mr + bc + 2*br + bias, clamped to 0..255
    function automatic logic [7:0] emboss_chan(
        input logic [7:0] tl,
        input logic [7:0] tc,
        input logic [7:0] ml,
        input logic [7:0] mc,
        input logic [7:0] mr,
        input logic [7:0] bc,
        input logic [7:0] br,
        input logic [7:0] bias
    );
        logic        [10:0] pos;
        logic        [9:0]  neg;
        logic signed [11:0] v;
        pos = 11'(mc) + 11'(mr) + 11'(bc) + {2'b00, br, 1'b0} + 11'(bias);
        neg = {1'b0, tl, 1'b0} + 10'(tc) + 10'(ml);
        v   = $signed({1'b0, pos}) - $signed({2'b00, neg});
        if (v[11])
        begin
            emboss_chan = 8'h00;
        end
        else if (v > 12'sd255)
        begin
            emboss_chan = 8'hFF;
        end
        else
        begin
            emboss_chan = v[7:0];
        end
    endfunction

endpackage

@@ rtl/emb_line_store.sv @@
// Two line stores in one memory: read-old-then-write per entry, with bypass.
module emb_line_store #(
    parameter int DEPTH = emb_pkg::MAX_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  emb_pkg::line_entry_t     wr_data,
    output emb_pkg::line_entry_t     rd_data
);
    import emb_pkg::*;

    line_entry_t mem [DEPTH];
    line_entry_t q_reg;
    line_entry_t fwd_reg;
    logic        hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg   <= mem[rd_addr];
            fwd_reg <= wr_data;
        end
    end

    // A read that lands on the entry written at the same edge takes the new data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = hit_reg ? fwd_reg : q_reg;

endmodule

@@ rtl/emb_cell.sv @@
// One column cell of the 3x3 window: takes its neighbor's column on each beat.
module emb_cell (
    input  logic             clk,
    input  logic             shift,
    input  emb_pkg::column_t col_in,
    output emb_pkg::column_t col_out
);
    import emb_pkg::*;

    column_t col_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

@@ rtl/emboss_3x3_convolution_top.sv @@
// 3x3 emboss filter over a raster RGB stream: counters, line store, window cells, output.
// Throughput: one beat per cycle unless result_stall holds a full result register;
// the line store is read on each advance and written per beat in stage B. A pixel's
//   result is completed by the beat image_width + 1 beats later; B and C lead to out_reg.
// Reset clears counters, valid bits and registers to 640 / 480 / 128; the line store
//   is not cleared and needs no clearing pass (stale entries are always masked off).
module emboss_3x3_convolution_top #(
    parameter int MAX_WIDTH  = emb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = emb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [emb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [emb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             pixel_valid,
    output logic                             pixel_stall,
    input  emb_pkg::pixel_t                  pixel,
    output logic                             result_valid,
    input  logic                             result_stall,
    output emb_pkg::result_t                 result
);
    import emb_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int RW   = $clog2(MAX_HEIGHT + 2);
    localparam int RRW  = $clog2(MAX_HEIGHT);
    localparam int CMPW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
    localparam int CMPH = (HW > HEIGHT_REG_W) ? HW : HEIGHT_REG_W;

    // configuration
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [BIAS_W-1:0]       bias_reg;
    logic                    restart;
    logic [CMPW-1:0]         w_raw;
    logic [CMPH-1:0]         h_raw;
    logic [WW-1:0]           eff_w;
    logic [HW-1:0]           eff_h;

    // input position and result position
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  res_col_reg, res_col_next;
    logic [RRW-1:0] res_row_reg, res_row_next;

    logic        adv;
    logic        ignore;
    logic        take;
    logic        in_frame;
    logic        col_last;
    logic        res_col_last;
    logic        res_row_last;
    rgb_t        pix;
    tap_ctrl_t   ctrl;

    // stage B: line store data arrives
    logic        b_valid_reg;
    rgb_t        b_pix_reg;
    logic [CW-1:0] b_addr_reg;
    tap_ctrl_t   b_ctrl_reg;
    line_entry_t lb_q;
    line_entry_t lb_wdata;
    column_t     new_col;

    // stage C: window cells hold the neighborhood
    logic        c_valid_reg;
    tap_ctrl_t   c_ctrl_reg;
    column_t     win_col [3];
    rgb_t        tap [9];

    logic        out_valid_reg;
    result_t     out_reg;
    result_t     out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            bias_reg   <= RESET_BIAS;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                REG_BIAS_OFFSET:  bias_reg   <= cfg_data[BIAS_W-1:0];
                default:          ;
            endcase
        end
    end

    assign restart = cfg_wen
                  && ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

    assign w_raw = CMPW'(width_reg);
    assign h_raw = CMPH'(height_reg);

    always_comb
    begin
        if (w_raw == '0)
        begin
            eff_w = WW'(1);
        end
        else if (w_raw > CMPW'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(w_raw);
        end
        if (h_raw == '0)
        begin
            eff_h = HW'(1);
        end
        else if (h_raw > CMPH'(MAX_HEIGHT))
        begin
            eff_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HW'(h_raw);
        end
    end

    // whole pipeline moves when the result register is free or being emptied
    assign adv         = !out_valid_reg || !result_stall;
    assign pixel_stall = !adv;

    // drop a flush beat that arrives before any beat of the frame
    assign ignore   = pixel.action && (col_reg == '0) && (row_reg == '0);
    assign take     = pixel_valid && adv && !ignore;
    assign in_frame = row_reg < RW'(eff_h);

    always_comb
    begin
        if (!pixel.action && in_frame)
        begin
            pix.red   = pixel.red;
            pix.green = pixel.green;
            pix.blue  = pixel.blue;
        end
        else
        begin
            pix = '0;
        end
    end

    assign col_last     = WW'(col_reg) == (eff_w - WW'(1));
    assign res_col_last = WW'(res_col_reg) == (eff_w - WW'(1));
    assign res_row_last = HW'(res_row_reg) == (eff_h - HW'(1));

    always_comb
    begin
        ctrl.emit      = (row_reg > RW'(1)) || ((row_reg == RW'(1)) && (col_reg != '0));
        ctrl.frame_end = ctrl.emit && res_col_last && res_row_last;
        ctrl.top       = res_row_reg != '0;
        ctrl.bot       = !res_row_last;
        ctrl.left      = res_col_reg != '0;
        ctrl.right     = !res_col_last;

        col_next     = col_last ? '0 : col_reg + CW'(1);
        row_next     = col_last ? row_reg + RW'(1) : row_reg;
        res_col_next = res_col_reg;
        res_row_next = res_row_reg;
        if (ctrl.frame_end)
        begin
            col_next     = '0;
            row_next     = '0;
            res_col_next = '0;
            res_row_next = '0;
        end
        else if (ctrl.emit)
        begin
            if (res_col_last)
            begin
                res_col_next = '0;
                res_row_next = res_row_reg + RRW'(1);
            end
            else
            begin
                res_col_next = res_col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            res_col_reg <= '0;
            res_row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            res_col_reg <= '0;
            res_row_reg <= '0;
        end
        else if (take)
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            res_col_reg <= res_col_next;
            res_row_reg <= res_row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg   <= take;
            c_valid_reg   <= b_valid_reg && b_ctrl_reg.emit;
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_pix_reg  <= pix;
            b_addr_reg <= col_reg;
            b_ctrl_reg <= ctrl;
            c_ctrl_reg <= b_ctrl_reg;
        end
        if (adv && c_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    // upper takes the old lower row, lower takes the new pixel
    assign lb_wdata.upper = lb_q.lower;
    assign lb_wdata.lower = b_pix_reg;

    emb_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (adv),
        .rd_addr (col_reg),
        .wr_en   (adv && b_valid_reg),
        .wr_addr (b_addr_reg),
        .wr_data (lb_wdata),
        .rd_data (lb_q)
    );

    assign new_col.up  = lb_q.upper;
    assign new_col.mid = lb_q.lower;
    assign new_col.low = b_pix_reg;

    emb_cell u_cell2 (
        .clk     (clk),
        .shift   (adv && b_valid_reg),
        .col_in  (new_col),
        .col_out (win_col[2])
    );

    emb_cell u_cell1 (
        .clk     (clk),
        .shift   (adv && b_valid_reg),
        .col_in  (win_col[2]),
        .col_out (win_col[1])
    );

    emb_cell u_cell0 (
        .clk     (clk),
        .shift   (adv && b_valid_reg),
        .col_in  (win_col[1]),
        .col_out (win_col[0])
    );

    // zero the taps that fall outside the frame
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tap[i]     = win_col[i].up;
            tap[3 + i] = win_col[i].mid;
            tap[6 + i] = win_col[i].low;
        end
        if (!c_ctrl_reg.top)
        begin
            tap[0] = '0;
            tap[1] = '0;
            tap[2] = '0;
        end
        if (!c_ctrl_reg.bot)
        begin
            tap[6] = '0;
            tap[7] = '0;
            tap[8] = '0;
        end
        if (!c_ctrl_reg.left)
        begin
            tap[0] = '0;
            tap[3] = '0;
            tap[6] = '0;
        end
        if (!c_ctrl_reg.right)
        begin
            tap[2] = '0;
            tap[5] = '0;
            tap[8] = '0;
        end
    end

    always_comb
    begin
        out_next.out_blue  = emboss_chan(tap[0].blue, tap[1].blue, tap[3].blue, tap[4].blue,
                                         tap[5].blue, tap[7].blue, tap[8].blue, bias_reg);
        out_next.out_green = emboss_chan(tap[0].green, tap[1].green, tap[3].green,
                                         tap[4].green, tap[5].green, tap[7].green,
                                         tap[8].green, bias_reg);
        out_next.out_red   = emboss_chan(tap[0].red, tap[1].red, tap[3].red, tap[4].red,
                                         tap[5].red, tap[7].red, tap[8].red, bias_reg);
        out_next.frame_end = c_ctrl_reg.frame_end;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ rtl/emb_checker.sv @@
// Port-level checks on the emboss filter, bound to the top level.
module emb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              pixel_valid,
    input logic              pixel_stall,
    input emb_pkg::pixel_t   pixel,
    input logic              result_valid,
    input logic              result_stall,
    input emb_pkg::result_t  result
);
    import emb_pkg::*;

    // a stalled pixel beat holds
    a_pixel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
        else $error("pixel beat changed while stalled");

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // the input side is held off only by back-pressure on a full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> result_valid && result_stall)
        else $error("input stalled without output back-pressure");

    // a new result is loaded only by an advance of the pipeline
    a_rise_adv: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!pixel_stall))
        else $error("result appeared while the pipeline was held");

endmodule

bind emboss_3x3_convolution_top emb_checker u_emb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

@@ test/emboss_checker.sv @@
`timescale 1ns / 100ps
// Emboss filter checker: tracks the window state, predicts every result beat and compares it.
module emboss_checker #(
    parameter int MAX_WIDTH  = emb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = emb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [emb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [emb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            pixel_valid,
    input  logic                            pixel_stall,
    input  emb_pkg::pixel_t                 pixel,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  emb_pkg::result_t                result,
    output int                              error_count,
    output int                              outstanding
);

    // Pixels are kept as blue in [7:0], green in [15:8], red in [23:16].
    logic [23:0]      line_upper [MAX_WIDTH];
    logic [23:0]      line_lower [MAX_WIDTH];
    logic [8:0][23:0] win;
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      res_col;
    int unsigned      res_row;
    longint unsigned  emitted;
    int unsigned      width_reg;
    int unsigned      height_reg;
    int unsigned      bias_reg;

    emb_pkg::result_t embossed_q [$];

    function automatic int unsigned clamped(input int unsigned v, input int unsigned hi);
        return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function automatic void restart_frame();
        col_pos = 0;
        row_pos = 0;
        emitted = 0;
        res_col = 0;
        res_row = 0;
    endfunction

    function automatic logic [7:0] emboss_level(input logic [8:0][23:0] t, input int sh);
        int v;
        v = -2 * int'(t[0][sh +: 8]) - int'(t[1][sh +: 8]) - int'(t[3][sh +: 8])
            + int'(t[4][sh +: 8]) + int'(t[5][sh +: 8]) + int'(t[7][sh +: 8])
            + 2 * int'(t[8][sh +: 8]) + int'(bias_reg);
        if (v < 0)
        begin
            return 8'h00;
        end
        if (v > 255)
        begin
            return 8'hFF;
        end
        return v[7:0];
    endfunction

    function automatic void predict_embossed(input emb_pkg::pixel_t beat);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        longint unsigned  total;
        longint unsigned  n;
        logic [23:0]      pix;
        logic [23:0]      up;
        logic [23:0]      lo;
        logic [8:0][23:0] taps;
        logic             top_ok;
        logic             bot_ok;
        logic             left_ok;
        logic             right_ok;
        logic             keep;
        emb_pkg::result_t res;

        w = clamped(width_reg, MAX_WIDTH);
        h = clamped(height_reg, MAX_HEIGHT);
        total = w;
        total = total * h;

        // Drop a flush that arrives before the frame has started.
        if (beat.action && col_pos == 0 && row_pos == 0)
        begin
            return;
        end

        n = row_pos;
        n = n * w + col_pos;
        pix = '0;
        if (!beat.action && n < total)
        begin
            pix = {beat.red, beat.green, beat.blue};
        end

        c = col_pos % MAX_WIDTH;
        up = line_upper[c];
        lo = line_lower[c];
        line_upper[c] = lo;
        line_lower[c] = pix;
        for (r = 0; r < 3; r++)
        begin
            win[r * 3]     = win[r * 3 + 1];
            win[r * 3 + 1] = win[r * 3 + 2];
        end
        win[2] = up;
        win[5] = lo;
        win[8] = pix;

        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end

        if (n < w + 1)
        begin
            return;
        end

        top_ok   = res_row > 0;
        bot_ok   = res_row + 1 < h;
        left_ok  = res_col > 0;
        right_ok = res_col + 1 < w;
        for (r = 0; r < 9; r++)
        begin
            keep = !((r / 3 == 0 && !top_ok) || (r / 3 == 2 && !bot_ok)
                     || (r % 3 == 0 && !left_ok) || (r % 3 == 2 && !right_ok));
            taps[r] = keep ? win[r] : 24'h0;
        end

        res.out_blue  = emboss_level(taps, 0);
        res.out_green = emboss_level(taps, 8);
        res.out_red   = emboss_level(taps, 16);
        res.frame_end = (emitted + 1 >= total);
        embossed_q.push_back(res);

        if (res.frame_end)
        begin
            restart_frame();
        end
        else
        begin
            emitted++;
            res_col++;
            if (res_col >= w)
            begin
                res_col = 0;
                res_row++;
            end
        end
    endfunction

    function automatic int field_mismatch(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        emb_pkg::result_t expected;
        int               errs;
        int               i;

        if (!rst_n)
        begin
            for (i = 0; i < MAX_WIDTH; i++)
            begin
                line_upper[i] = '0;
                line_lower[i] = '0;
            end
            win        = '0;
            width_reg  = emb_pkg::RESET_WIDTH;
            height_reg = emb_pkg::RESET_HEIGHT;
            bias_reg   = emb_pkg::RESET_BIAS;
            restart_frame();
            embossed_q.delete();
            error_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_wen)
            begin
                case (cfg_index)
                    emb_pkg::REG_IMAGE_WIDTH:
                    begin
                        width_reg = cfg_data[emb_pkg::WIDTH_REG_W-1:0];
                        restart_frame();
                    end
                    emb_pkg::REG_IMAGE_HEIGHT:
                    begin
                        height_reg = cfg_data[emb_pkg::HEIGHT_REG_W-1:0];
                        restart_frame();
                    end
                    emb_pkg::REG_BIAS_OFFSET:
                    begin
                        bias_reg = cfg_data[emb_pkg::BIAS_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (result_valid && !result_stall)
            begin
                if (embossed_q.size() == 0)
                begin
                    $error("result beat with nothing expected: %p", result);
                    errs++;
                end
                else
                begin
                    expected = embossed_q.pop_front();
                    errs += field_mismatch("out_blue", expected.out_blue, result.out_blue);
                    errs += field_mismatch("out_green", expected.out_green, result.out_green);
                    errs += field_mismatch("out_red", expected.out_red, result.out_red);
                    errs += field_mismatch("frame_end", 8'(expected.frame_end),
                                           8'(result.frame_end));
                end
            end

            // A pixel beat can never complete in the same cycle it enters.
            if (pixel_valid && !pixel_stall)
            begin
                predict_embossed(pixel);
            end

            error_count <= error_count + errs;
            outstanding <= embossed_q.size();
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Emboss filter test top: clock, reset, pixel stimulus, result stall pattern and verdict.
module testbench;

    localparam int LIMIT_CYCLES  = 3_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 700;
    localparam int CLAMP_ITEMS   = 40;
    localparam logic [emb_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            cfg_wen      = 1'b0;
    logic [emb_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [emb_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                            pixel_valid  = 1'b0;
    logic                            pixel_stall;
    emb_pkg::pixel_t                 pixel        = '0;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    emb_pkg::result_t                result;

    int          error_count;
    int          outstanding;
    int          cycle_count  = 0;
    logic        stall_on     = 1'b0;
    int          stall_left   = 0;
    int          run_left     = 0;
    bit          send_gaps    = 1'b0;
    int unsigned cur_w;
    int unsigned cur_h;
    int          counted_items = 0;

    emboss_3x3_convolution_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    emboss_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .error_count  (error_count),
        .outstanding  (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 8'h00;
        end
        if (r == 1)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic emb_pkg::pixel_t beat_of(input logic action, input logic [7:0] b,
                                                input logic [7:0] g, input logic [7:0] r);
        emb_pkg::pixel_t beat;
        beat.action = action;
        beat.blue   = b;
        beat.green  = g;
        beat.red    = r;
        return beat;
    endfunction

    function automatic emb_pkg::pixel_t random_beat(input logic action);
        return beat_of(action, rand_level(), rand_level(), rand_level());
    endfunction

    // Result side: alternate free runs and stall bursts while enabled.
    always @(posedge clk)
    begin
        if (!stall_on)
        begin
            result_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else if (run_left > 0)
        begin
            result_stall <= 1'b0;
            run_left     <= run_left - 1;
        end
        else
        begin
            result_stall <= 1'b0;
            run_left     <= $urandom_range(0, 12);
            stall_left   <= pick_gap();
        end
    end

    task automatic write_reg(input logic [emb_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [emb_pkg::CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [emb_pkg::CFG_DATA_W-1:0] wd,
                                input logic [emb_pkg::CFG_DATA_W-1:0] hd);
        write_reg(emb_pkg::REG_IMAGE_WIDTH, wd);
        write_reg(emb_pkg::REG_IMAGE_HEIGHT, hd);
        cur_w = (wd[11:0] == 0) ? 1 :
                ((wd[11:0] > emb_pkg::MAX_WIDTH_DEF) ? emb_pkg::MAX_WIDTH_DEF : wd[11:0]);
        cur_h = (hd == 0) ? 1 : ((hd > emb_pkg::MAX_HEIGHT_DEF) ? emb_pkg::MAX_HEIGHT_DEF : hd);
    endtask

    // Hold the beat until accepted; valid stays high for back-to-back beats.
    task automatic send_beat(input emb_pkg::pixel_t beat);
        int gap;
        gap = send_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel       <= beat;
        pixel_valid <= 1'b1;
        @(posedge clk);
        while (pixel_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        pixel_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One frame of pixels, then the drain beats; early flushes and extra pixels mixed in.
    task automatic send_frame(input int unsigned w, input int unsigned h,
                              input int early_pct, input int extra_pct);
        int unsigned k;
        for (k = 0; k < w * h; k++)
        begin
            send_beat(random_beat($urandom_range(0, 99) < early_pct));
        end
        for (k = 0; k <= w; k++)
        begin
            send_beat(random_beat($urandom_range(0, 99) >= extra_pct));
        end
        counted_items += w * h + w + 1;
    endtask

    initial
    begin : stimulus
        int unsigned k;
        int unsigned n;
        int          kind;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 3x3 frame at full bias swing, ignored flush, early flush, extra pixels.
        set_geometry(13'd3, 13'd3);
        write_reg(emb_pkg::REG_BIAS_OFFSET, 13'd255);
        send_beat(beat_of(1'b1, 8'hFF, 8'hFF, 8'hFF));
        for (k = 0; k < 9; k++)
        begin
            if (k == 4)
            begin
                send_beat(beat_of(1'b1, 8'hFF, 8'hFF, 8'hFF));
            end
            else
            begin
                send_beat(beat_of(1'b0, (k % 2) ? 8'hFF : 8'h00,
                                  (k % 3 == 0) ? 8'hFF : 8'h00, (k > 4) ? 8'hFF : 8'h00));
            end
        end
        send_beat(beat_of(1'b1, 8'h00, 8'h00, 8'h00));
        send_beat(beat_of(1'b0, 8'hFF, 8'hFF, 8'hFF));
        send_beat(beat_of(1'b1, 8'h00, 8'h00, 8'h00));
        send_beat(beat_of(1'b0, 8'hFF, 8'h00, 8'hFF));
        wait_idle();

        // Single-pixel frame at zero bias, plus a write to the unused index.
        write_reg(emb_pkg::REG_BIAS_OFFSET, 13'd0);
        write_reg(REG_UNUSED, 13'h1FFF);
        set_geometry(13'd1, 13'd1);
        send_beat(beat_of(1'b0, 8'hFF, 8'hFF, 8'hFF));
        send_beat(beat_of(1'b1, 8'h00, 8'h00, 8'h00));
        send_beat(beat_of(1'b1, 8'h00, 8'h00, 8'h00));
        wait_idle();

        // Abandon a frame partway through by changing the geometry.
        set_geometry(13'd2, 13'd2);
        send_beat(beat_of(1'b0, 8'h80, 8'h7F, 8'h01));
        send_beat(beat_of(1'b0, 8'hFE, 8'h40, 8'hC0));
        wait_idle();
        set_geometry(13'd2, 13'd3);
        send_frame(cur_w, cur_h, 0, 0);

        counted_items = 0;
        while (counted_items < RANDOM_ITEMS)
        begin
            wait_idle();
            send_gaps = ($urandom_range(0, 3) != 0);
            stall_on <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 6)
            begin
                set_geometry(13'($urandom_range(0, 1) << 12) | 13'($urandom_range(0, 8)),
                             13'($urandom_range(0, 6)));
            end
            write_reg(emb_pkg::REG_BIAS_OFFSET, 13'(rand_level()));
            if ($urandom_range(0, 9) == 0)
            begin
                write_reg(REG_UNUSED, 13'($urandom_range(0, 8191)));
            end

            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                // Partial frame: may be picked up again or abandoned by the next phase.
                n = $urandom_range(1, cur_w * cur_h + cur_w);
                for (k = 0; k < n; k++)
                begin
                    send_beat(random_beat($urandom_range(0, 9) == 0));
                end
                counted_items += n;
            end
            else if (kind == 1)
            begin
                n = $urandom_range(1, cur_w * cur_h);
                for (k = 0; k < n; k++)
                begin
                    send_beat(random_beat($urandom_range(0, 1)));
                end
                counted_items += n;
            end
            else
            begin
                if ($urandom_range(0, 9) < 2)
                begin
                    n = $urandom_range(1, 3);
                    for (k = 0; k < n; k++)
                    begin
                        send_beat(random_beat(1'b1));
                    end
                end
                send_frame(cur_w, cur_h, 3, 25);
            end
        end

        // Largest geometries: start of a clamped full-width row, then of a full-height column.
        wait_idle();
        send_gaps = 1'b1;
        stall_on <= 1'b1;
        set_geometry(13'd4095, 13'd0);
        for (k = 0; k < CLAMP_ITEMS; k++)
        begin
            send_beat(random_beat($urandom_range(0, 9) == 0));
        end
        wait_idle();
        write_reg(emb_pkg::REG_BIAS_OFFSET, 13'd128);
        set_geometry(13'd0, 13'd8191);
        for (k = 0; k < CLAMP_ITEMS; k++)
        begin
            send_beat(random_beat($urandom_range(0, 9) == 0));
        end

        wait_idle();
        if (error_count == 0 && outstanding == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/emb_pkg.sv
rtl/emb_line_store.sv
rtl/emb_cell.sv
rtl/emboss_3x3_convolution_top.sv
rtl/emb_checker.sv
test/emboss_checker.sv
test/testbench.sv
